[design/bwscc_pkg.sv]
// bwscc_pkg: shared types, codes and timing tables for the bus wait-state cycle calculator
// no dependencies; used by bus_wait_state_cycle_calc
package bwscc_pkg;

    localparam int CMD_W    = 2;
    localparam int REGION_W = 8;
    localparam int COUNT_W  = 16;
    localparam int CYCLES_W = 8;
    localparam int WAITCNT_W = 11;
    localparam int TIME_W   = 4;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [REGION_W-1:0]  region_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CYCLES_W-1:0]  cycles_t;
    typedef logic [WAITCNT_W-1:0] waitcnt_t;
    typedef logic [TIME_W-1:0]    time_t;

    // command bits
    localparam int CMD_SEQ_BIT  = 0;
    localparam int CMD_WIDE_BIT = 1;

    // region codes
    localparam region_t REGION_BIOS     = 8'h00;
    localparam region_t REGION_UNUSED   = 8'h01;
    localparam region_t REGION_EWRAM    = 8'h02;
    localparam region_t REGION_IWRAM    = 8'h03;
    localparam region_t REGION_IO       = 8'h04;
    localparam region_t REGION_PALETTE  = 8'h05;
    localparam region_t REGION_VRAM     = 8'h06;
    localparam region_t REGION_OAM      = 8'h07;
    localparam region_t REGION_ROM_LO   = 8'h08;
    localparam region_t REGION_ROM_HI   = 8'h0D;
    localparam region_t REGION_SRAM     = 8'h0E;

    // rom window index
    localparam logic [1:0] WIN_0 = 2'd0;
    localparam logic [1:0] WIN_1 = 2'd1;
    localparam logic [1:0] WIN_2 = 2'd2;

    localparam time_t SEQ_FAST_TIME = 4'd2;
    localparam time_t SEQ_WIN0_TIME = 4'd3;
    localparam time_t SEQ_WIN1_TIME = 4'd5;
    localparam time_t SEQ_WIN2_TIME = 4'd9;
    localparam time_t EWRAM_TIME    = 4'd3;
    localparam time_t FAST_TIME     = 4'd1;
    localparam time_t NO_TIME       = 4'd0;

    // first-access select to cycles
    function automatic time_t first_access_time(input logic [1:0] sel);
        time_t t;
        case (sel)
            2'd0:    t = 4'd5;
            2'd1:    t = 4'd4;
            2'd2:    t = 4'd3;
            2'd3:    t = 4'd9;
            default: t = 4'd5;
        endcase
        return t;
    endfunction

endpackage

[design/bus_wait_state_cycle_calc.sv]
// bus_wait_state_cycle_calc: bus cycle count for one burst of accesses
// depends on bwscc_pkg for types, region codes and timing tables
//
// each beat passes the input register, then the result register, to the result beat
// throughput: one beat per cycle unless out_ready stalls, one compute stage
// reset: rst_n async active low clears both valid flags and wait_control to 0
module bus_wait_state_cycle_calc
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wait_control_wr_en,
    input  bwscc_pkg::waitcnt_t wait_control,
    input  logic                in_valid,
    output logic                in_ready,
    input  bwscc_pkg::cmd_t     command,
    input  bwscc_pkg::region_t  region,
    input  bwscc_pkg::count_t   access_count,
    output logic                out_valid,
    input  logic                out_ready,
    output bwscc_pkg::cycles_t  cycles
);

    bwscc_pkg::waitcnt_t wait_control_reg;

    logic                s1_valid_reg;
    bwscc_pkg::cmd_t     s1_cmd_reg;
    bwscc_pkg::region_t  s1_region_reg;
    bwscc_pkg::cycles_t  s1_count_reg;

    logic                out_valid_reg;
    bwscc_pkg::cycles_t  cycles_reg;
    bwscc_pkg::cycles_t  cycles_next;

    logic out_load;
    logic in_load;

    logic               wide;
    logic               seq;
    logic [1:0]         win;
    logic               is_rom;
    bwscc_pkg::time_t   t_first;
    bwscc_pkg::time_t   s_time;
    bwscc_pkg::time_t   mult;
    bwscc_pkg::cycles_t base;
    bwscc_pkg::cycles_t m;
    bwscc_pkg::cycles_t n;
    logic [bwscc_pkg::CYCLES_W+bwscc_pkg::TIME_W-1:0] prod;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_control_reg <= '0;
        end
        else if (wait_control_wr_en)
        begin
            wait_control_reg <= wait_control;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // only the low byte of the count matters, everything wraps mod 256
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_cmd_reg    <= command;
            s1_region_reg <= region;
            s1_count_reg  <= access_count[bwscc_pkg::CYCLES_W-1:0];
        end
    end

    // per-region access times
    always_comb
    begin
        wide    = s1_cmd_reg[bwscc_pkg::CMD_WIDE_BIT];
        seq     = s1_cmd_reg[bwscc_pkg::CMD_SEQ_BIT];
        n       = s1_count_reg;
        win     = s1_region_reg[2:1];
        is_rom  = 1'b0;
        t_first = bwscc_pkg::NO_TIME;
        s_time  = bwscc_pkg::SEQ_WIN0_TIME;

        case (win)
            bwscc_pkg::WIN_0:
            begin
                s_time = wait_control_reg[4] ? bwscc_pkg::SEQ_FAST_TIME
                                             : bwscc_pkg::SEQ_WIN0_TIME;
            end
            bwscc_pkg::WIN_1:
            begin
                s_time = wait_control_reg[7] ? bwscc_pkg::SEQ_FAST_TIME
                                             : bwscc_pkg::SEQ_WIN1_TIME;
            end
            default:
            begin
                s_time = wait_control_reg[10] ? bwscc_pkg::SEQ_FAST_TIME
                                              : bwscc_pkg::SEQ_WIN2_TIME;
            end
        endcase

        case (s1_region_reg) inside
            bwscc_pkg::REGION_BIOS, bwscc_pkg::REGION_IWRAM, bwscc_pkg::REGION_IO,
            bwscc_pkg::REGION_PALETTE, bwscc_pkg::REGION_VRAM, bwscc_pkg::REGION_OAM:
            begin
                t_first = bwscc_pkg::FAST_TIME;
            end
            bwscc_pkg::REGION_EWRAM:
            begin
                t_first = bwscc_pkg::EWRAM_TIME;
            end
            [bwscc_pkg::REGION_ROM_LO:bwscc_pkg::REGION_ROM_HI]:
            begin
                is_rom = 1'b1;
                case (win)
                    bwscc_pkg::WIN_0:
                        t_first = bwscc_pkg::first_access_time(wait_control_reg[3:2]);
                    bwscc_pkg::WIN_1:
                        t_first = bwscc_pkg::first_access_time(wait_control_reg[6:5]);
                    default:
                        t_first = bwscc_pkg::first_access_time(wait_control_reg[9:8]);
                endcase
            end
            bwscc_pkg::REGION_SRAM:
            begin
                t_first = bwscc_pkg::first_access_time(wait_control_reg[1:0]);
            end
            default:
            begin
                t_first = bwscc_pkg::NO_TIME;
            end
        endcase
    end

    // total = base + mult * m, all mod 256
    always_comb
    begin
        base = '0;
        mult = t_first;
        m    = n;
        case (s1_region_reg) inside
            bwscc_pkg::REGION_BIOS, bwscc_pkg::REGION_IWRAM,
            bwscc_pkg::REGION_IO, bwscc_pkg::REGION_OAM:
            begin
                // 32-bit bus, no doubling
                m = n;
            end
            default:
            begin
                if (is_rom)
                begin
                    mult = s_time;
                    if (seq)
                    begin
                        m = wide ? {n[bwscc_pkg::CYCLES_W-2:0], 1'b0} : n;
                    end
                    else
                    begin
                        base = {{(bwscc_pkg::CYCLES_W-bwscc_pkg::TIME_W){1'b0}}, t_first};
                        m    = wide ? {n[bwscc_pkg::CYCLES_W-2:0], 1'b1} - 8'd2 : n - 8'd1;
                    end
                end
                else
                begin
                    m = wide ? {n[bwscc_pkg::CYCLES_W-2:0], 1'b0} : n;
                end
            end
        endcase
        prod        = m * mult;
        cycles_next = base + prod[bwscc_pkg::CYCLES_W-1:0];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cycles_reg <= cycles_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cycles    = cycles_reg;

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for bus_wait_state_cycle_calc, with a small cost scoreboard
// depends on bwscc_pkg and bus_wait_state_cycle_calc; random beats with idle gaps on both sides

typedef struct {
    bwscc_pkg::cmd_t    cmd;
    bwscc_pkg::region_t region;
    bwscc_pkg::count_t  count;
    bwscc_pkg::cycles_t cost;
} burst_t;

class burst_cost_board;
    bwscc_pkg::waitcnt_t wait_ctl;
    burst_t              cost_q[$];
    int unsigned         fail_count;

    function new();
        wait_ctl   = '0;
        fail_count = 0;
    endfunction

    function void set_wait_control(bwscc_pkg::waitcnt_t value);
        wait_ctl = value;
    endfunction

    function int unsigned pending();
        return cost_q.size();
    endfunction

    function int unsigned select_time(logic [1:0] sel);
        case (sel)
            2'd0:    return 5;
            2'd1:    return 4;
            2'd2:    return 3;
            default: return 9;
        endcase
    endfunction

    function bwscc_pkg::cycles_t burst_cycles(bwscc_pkg::cmd_t cmd, bwscc_pkg::region_t region,
                                              bwscc_pkg::count_t count);
        int unsigned t;
        int unsigned s;
        int unsigned n;
        int unsigned win;
        int unsigned total;
        logic        wide;
        logic        seq;
        wide = cmd[bwscc_pkg::CMD_WIDE_BIT];
        seq  = cmd[bwscc_pkg::CMD_SEQ_BIT];
        n    = 32'(count);
        s    = 0;
        if (region < bwscc_pkg::REGION_ROM_LO)
        begin
            case (region)
                bwscc_pkg::REGION_UNUSED: t = 32'(bwscc_pkg::NO_TIME);
                bwscc_pkg::REGION_EWRAM:  t = 32'(bwscc_pkg::EWRAM_TIME);
                default:                  t = 32'(bwscc_pkg::FAST_TIME);
            endcase
        end
        else if (region <= bwscc_pkg::REGION_ROM_HI)
        begin
            win = (32'(region) - 32'(bwscc_pkg::REGION_ROM_LO)) >> 1;
            t   = select_time(wait_ctl[2 + 3 * win +: 2]);
            if (wait_ctl[4 + 3 * win])
                s = 32'(bwscc_pkg::SEQ_FAST_TIME);
            else if (win == 32'(bwscc_pkg::WIN_0))
                s = 32'(bwscc_pkg::SEQ_WIN0_TIME);
            else if (win == 32'(bwscc_pkg::WIN_1))
                s = 32'(bwscc_pkg::SEQ_WIN1_TIME);
            else
                s = 32'(bwscc_pkg::SEQ_WIN2_TIME);
        end
        else if (region == bwscc_pkg::REGION_SRAM)
            t = select_time(wait_ctl[1:0]);
        else
            t = 32'(bwscc_pkg::NO_TIME);

        // 32-bit-bus regions cost the same for every access width
        if (region == bwscc_pkg::REGION_BIOS || region == bwscc_pkg::REGION_IWRAM ||
            region == bwscc_pkg::REGION_IO || region == bwscc_pkg::REGION_OAM)
            total = t * n;
        else if (region >= bwscc_pkg::REGION_ROM_LO && region <= bwscc_pkg::REGION_ROM_HI)
        begin
            if (seq)
                total = s * n * (wide ? 2 : 1);
            else
                // n = 0 wraps the sequential part, giving t - s
                total = t + s * (wide ? (2 * n - 1) : (n - 1));
        end
        else
            total = t * n * (wide ? 2 : 1);
        return total[7:0];
    endfunction

    function void note_input(bwscc_pkg::cmd_t cmd, bwscc_pkg::region_t region,
                             bwscc_pkg::count_t count);
        burst_t b;
        b.cmd    = cmd;
        b.region = region;
        b.count  = count;
        b.cost   = burst_cycles(cmd, region, count);
        cost_q.push_back(b);
    endfunction

    function void check_result(bwscc_pkg::cycles_t got);
        burst_t want;
        if (cost_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result beat: cycles %0d", got);
            return;
        end
        want = cost_q.pop_front();
        if (got !== want.cost)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display({"mismatch: cmd %0d region 0x%02h count %0d wait_ctl 0x%03h: ",
                          "expected %0d got %0d"},
                         want.cmd, want.region, want.count, wait_ctl, want.cost, got);
        end
    endfunction
endclass

module tb_top;

    localparam bwscc_pkg::cmd_t CMD_NSEQ16 = 2'd0;
    localparam bwscc_pkg::cmd_t CMD_SEQ16  = 2'd1;
    localparam bwscc_pkg::cmd_t CMD_NSEQ32 = 2'd2;
    localparam bwscc_pkg::cmd_t CMD_SEQ32  = 2'd3;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 225;

    logic                clk;
    logic                rst_n;
    logic                wait_control_wr_en;
    bwscc_pkg::waitcnt_t wait_control;
    logic                in_valid;
    logic                in_ready;
    bwscc_pkg::cmd_t     command;
    bwscc_pkg::region_t  region;
    bwscc_pkg::count_t   access_count;
    logic                out_valid;
    logic                out_ready;
    bwscc_pkg::cycles_t  cycles;

    bit tx_idle_on;
    bit rx_idle_on;

    burst_cost_board sb = new();

    bus_wait_state_cycle_calc u_top
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .wait_control_wr_en (wait_control_wr_en),
        .wait_control       (wait_control),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .region             (region),
        .access_count       (access_count),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .cycles             (cycles)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("FAIL");
        $finish;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // called and returns at a falling edge
    task automatic push_burst(bwscc_pkg::cmd_t cmd, bwscc_pkg::region_t rgn,
                              bwscc_pkg::count_t count);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command      = cmd;
        region       = rgn;
        access_count = count;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(cmd, rgn, count);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_wait_control(bwscc_pkg::waitcnt_t value);
        wait_control_wr_en = 1'b1;
        wait_control       = value;
        @(negedge clk);
        wait_control_wr_en = 1'b0;
        sb.set_wait_control(value);
    endtask

    task automatic push_random_burst();
        int                 r;
        bwscc_pkg::region_t rgn;
        bwscc_pkg::count_t  count;
        r = $urandom_range(0, 99);
        if (r < 60)
            rgn = bwscc_pkg::region_t'($urandom_range(bwscc_pkg::REGION_ROM_LO,
                                                      bwscc_pkg::REGION_SRAM));
        else if (r < 85)
            rgn = bwscc_pkg::region_t'($urandom_range(0, 15));
        else
            rgn = bwscc_pkg::region_t'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 50)
            count = bwscc_pkg::count_t'($urandom_range(0, 15));
        else if (r < 70)
            count = bwscc_pkg::count_t'($urandom_range(0, 255));
        else
            count = bwscc_pkg::count_t'($urandom_range(0, 65535));
        push_burst(bwscc_pkg::cmd_t'($urandom_range(0, 3)), rgn, count);
    endtask

    task automatic run_directed();
        int k;
        // every low region once, command cycling through all four, count 16'hFFFF, 1 or 7
        for (k = 0; k < 16; k++)
            push_burst(bwscc_pkg::cmd_t'(k), bwscc_pkg::region_t'(k),
                       (k % 3 == 0) ? 16'hFFFF : ((k % 3 == 1) ? 16'd1 : 16'd7));
        push_burst(CMD_SEQ32, 8'hFF, 16'hFFFF);
        push_burst(CMD_NSEQ16, 8'h80, 16'hAAAA);
        push_burst(CMD_SEQ16, bwscc_pkg::REGION_ROM_HI, 16'h5555);
        // zero-length bursts on the rom windows and sram
        push_burst(CMD_NSEQ16, bwscc_pkg::REGION_ROM_LO, 16'd0);
        push_burst(CMD_SEQ16, bwscc_pkg::REGION_ROM_LO, 16'd0);
        push_burst(CMD_NSEQ32, 8'h0A, 16'd0);
        push_burst(CMD_SEQ32, 8'h0B, 16'd0);
        push_burst(CMD_NSEQ32, 8'h0C, 16'd0);
        push_burst(CMD_NSEQ16, bwscc_pkg::REGION_SRAM, 16'd0);
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && rx_idle_on)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(cycles);

    initial
    begin : stimulus
        int phase;
        int k;
        rst_n              = 1'b0;
        wait_control_wr_en = 1'b0;
        wait_control       = '0;
        in_valid           = 1'b0;
        command            = CMD_NSEQ16;
        region             = bwscc_pkg::REGION_BIOS;
        access_count       = '0;
        out_ready          = 1'b0;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drain();
            // reset value first, then both extremes, then random settings
            case (phase)
                0:       ;
                1:       write_wait_control(11'h7FF);
                2:       write_wait_control(11'h000);
                default: write_wait_control(bwscc_pkg::waitcnt_t'($urandom_range(0, 2047)));
            endcase
            tx_idle_on = (phase != 2 && phase != 6);
            rx_idle_on = (phase != 2 && phase != 5);
            for (k = 0; k < PHASE_ITEMS; k++)
                push_random_burst();
        end
        wait_drain();

        if (sb.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
